FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. All checks are disabled while the
// active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Condition that must never be true.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");

`endif

FILE: rtl/crfe_pkg.sv
`default_nettype none

package crfe_pkg;

    // Request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_DRAW  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // Shape kinds (character codes)
    localparam logic [7:0] KIND_OUTLINE = 8'h63;
    localparam logic [7:0] KIND_FILLED  = 8'h43;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_BAD   = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Config register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND   = 2'd2;

    localparam int          CFG_DATA_W    = 9;
    localparam int          DIM_W         = 9;
    localparam int          COORD_W       = 20;
    localparam int          RMAG_W        = COORD_W - 1;
    localparam int          RSQ_W         = 2 * RMAG_W;
    localparam logic [7:0]  BG_RESET      = 8'd32;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [7:0]                shape_kind;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] radius;
        logic [7:0]                color;
        logic [7:0]                read_col;
        logic [7:0]                read_row;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] pixel_value;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/crfe_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module crfe_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 65536
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  wire logic [DATA_W-1:0]         wr_data,
    input  wire logic                      rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
    output logic      [DATA_W-1:0]         rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/circle_raster_fill_engine_top.sv
// Flow: draw = setup, sweep, drain; clear = sweep, drain; read = RAM read; then the result.
// Throughput: one transaction at a time; the sweep writes one pixel per cycle on the
//   single frame RAM write port, so clear and draw visit all W*H pixels (65536 at full size).
// Reset: aresetn is synchronous, active low; clears FSM, valids and config registers.
// Frame RAM is not cleared; pixels are undefined until a clear or draw writes them.
`default_nettype none
`include "assert_macros.svh"

module circle_raster_fill_engine_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // request channel
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire crfe_pkg::req_t                   s_data,
    // result channel
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output crfe_pkg::rsp_t                        m_data,
    // config write port
    input  wire logic                             cfg_we,
    input  wire logic [1:0]                       cfg_index,
    input  wire logic [crfe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW1    = $clog2(MAX_WIDTH + 1);   // holds active width
    localparam int RW1    = $clog2(MAX_HEIGHT + 1);  // holds active height
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int CRD_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + FRAC_BITS;
    // magnitude of (coord << FRAC_BITS) - center always fits AW bits
    localparam int AW     = ((CRD_W > crfe_pkg::RMAG_W) ? CRD_W : crfe_pkg::RMAG_W) + 1;
    localparam int DW     = AW + 1;
    localparam int SQ_W   = 2 * AW;
    localparam int D2_W   = SQ_W + 1;
    localparam int R1_W   = crfe_pkg::COORD_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [crfe_pkg::DIM_W-1:0] frame_width_reg;
    logic [crfe_pkg::DIM_W-1:0] frame_height_reg;
    logic [7:0]                 background_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= '0;
            frame_height_reg <= '0;
            background_reg   <= crfe_pkg::BG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                crfe_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                crfe_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                crfe_pkg::CFG_BACKGROUND:   background_reg   <= cfg_wdata[7:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // Oversized width/height clamp to the frame store size.
    logic [CW1-1:0] act_w;
    logic [RW1-1:0] act_h;

    assign act_w = (32'(frame_width_reg) > 32'(MAX_WIDTH)) ? CW1'(MAX_WIDTH)
                                                           : CW1'(frame_width_reg);
    assign act_h = (32'(frame_height_reg) > 32'(MAX_HEIGHT)) ? RW1'(MAX_HEIGHT)
                                                             : RW1'(frame_height_reg);

    // ------------------------------------------------------------------
    // Request decode (valid only with an accepted transaction)
    // ------------------------------------------------------------------
    logic s_accept;
    logic frame_empty;
    logic bad_draw;
    logic read_oob;

    assign s_accept    = s_valid && s_ready;
    assign frame_empty = (act_w == '0) || (act_h == '0);
    assign bad_draw    = ((s_data.shape_kind != crfe_pkg::KIND_OUTLINE) &&
                          (s_data.shape_kind != crfe_pkg::KIND_FILLED)) ||
                         s_data.radius[crfe_pkg::COORD_W-1] || (s_data.radius == '0);
    assign read_oob    = (32'(s_data.read_col) >= 32'(act_w)) ||
                         (32'(s_data.read_row) >= 32'(act_h));

    // ------------------------------------------------------------------
    // FSM
    // ------------------------------------------------------------------
    crfe_pkg::state_t state_reg, state_next;

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             last_col;
    logic             last_pix;
    logic             pipe_busy;
    logic             va_reg, vb_reg, vc_reg;
    logic             m_valid_reg;

    assign last_col  = (CW1'(col_reg) == (act_w - CW1'(1)));
    assign last_pix  = last_col && (RW1'(row_reg) == (act_h - RW1'(1)));
    assign pipe_busy = va_reg || vb_reg || vc_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            crfe_pkg::ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.req_type)
                        crfe_pkg::REQ_CLEAR:
                            state_next = frame_empty ? crfe_pkg::ST_DONE : crfe_pkg::ST_SWEEP;
                        crfe_pkg::REQ_DRAW:
                            state_next = (bad_draw || frame_empty) ? crfe_pkg::ST_DONE
                                                                   : crfe_pkg::ST_SETUP;
                        crfe_pkg::REQ_READ:
                            state_next = read_oob ? crfe_pkg::ST_DONE : crfe_pkg::ST_READ;
                        crfe_pkg::REQ_NONE:
                            state_next = crfe_pkg::ST_DONE;
                    endcase
                end
            end
            crfe_pkg::ST_SETUP: state_next = crfe_pkg::ST_SWEEP;
            crfe_pkg::ST_SWEEP: begin
                if (last_pix) begin
                    state_next = crfe_pkg::ST_DRAIN;
                end
            end
            crfe_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = crfe_pkg::ST_DONE;
                end
            end
            crfe_pkg::ST_READ: state_next = crfe_pkg::ST_DONE;
            crfe_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = crfe_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crfe_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // FSM outputs
    logic issue;      // sweep emits one pixel this cycle
    logic out_load;   // result moves into the output register
    logic read_cap;   // RAM read data is valid

    always_comb begin
        s_ready  = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        read_cap = 1'b0;
        unique case (state_reg)
            crfe_pkg::ST_IDLE:  s_ready  = 1'b1;
            crfe_pkg::ST_SETUP: ;
            crfe_pkg::ST_SWEEP: issue    = 1'b1;
            crfe_pkg::ST_DRAIN: ;
            crfe_pkg::ST_READ:  read_cap = 1'b1;
            crfe_pkg::ST_DONE:  out_load = !m_valid_reg || m_ready;
        endcase
    end

    // ------------------------------------------------------------------
    // Per-transaction registers
    // ------------------------------------------------------------------
    logic                               clear_mode_reg;
    logic                               outline_reg;
    logic signed [crfe_pkg::COORD_W-1:0] cx_reg, cy_reg, r_reg;
    logic [7:0]                         color_reg;
    logic [1:0]                         res_status_reg;
    logic [7:0]                         res_pix_reg;
    logic [crfe_pkg::RSQ_W-1:0]         rr_reg;
    logic [crfe_pkg::RSQ_W-1:0]         rr1_reg;
    logic                               r1_neg_reg;
    logic signed [R1_W-1:0]             r1;
    logic [7:0]                         rd_data;

    // radius minus one pixel; negative means the inner test never rejects
    assign r1 = R1_W'(r_reg) - $signed(R1_W'(1) << FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            clear_mode_reg <= (s_data.req_type == crfe_pkg::REQ_CLEAR);
            outline_reg    <= (s_data.shape_kind == crfe_pkg::KIND_OUTLINE);
            cx_reg         <= s_data.center_x;
            cy_reg         <= s_data.center_y;
            r_reg          <= s_data.radius;
            color_reg      <= s_data.color;
            res_pix_reg    <= '0;
            if (s_data.req_type == crfe_pkg::REQ_DRAW && bad_draw) begin
                res_status_reg <= crfe_pkg::STATUS_BAD;
            end else if (s_data.req_type == crfe_pkg::REQ_READ && read_oob) begin
                res_status_reg <= crfe_pkg::STATUS_RANGE;
            end else begin
                res_status_reg <= crfe_pkg::STATUS_OK;
            end
        end
        if (read_cap) begin
            res_pix_reg <= rd_data;
        end
        if (state_reg == crfe_pkg::ST_SETUP) begin
            rr_reg     <= r_reg[crfe_pkg::RMAG_W-1:0] * r_reg[crfe_pkg::RMAG_W-1:0];
            rr1_reg    <= r1[crfe_pkg::RMAG_W-1:0] * r1[crfe_pkg::RMAG_W-1:0];
            r1_neg_reg <= r1[R1_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Sweep counters: row-major over the active area
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (issue) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel pipeline: offsets -> squares -> sum -> test and write
    // ------------------------------------------------------------------
    logic signed [DW-1:0] px_s, qy_s;
    logic [AW-1:0]        a_px_reg, a_qy_reg;
    logic [ADDR_W-1:0]    a_addr_reg, b_addr_reg, c_addr_reg;
    logic [SQ_W-1:0]      b_pp_reg, b_qq_reg;
    logic [D2_W-1:0]      c_d2_reg;

    assign px_s = $signed(DW'({col_reg, {FRAC_BITS{1'b0}}})) - DW'(cx_reg);
    assign qy_s = $signed(DW'({row_reg, {FRAC_BITS{1'b0}}})) - DW'(cy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            va_reg <= issue;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        a_px_reg   <= px_s[DW-1] ? AW'(-px_s) : AW'(px_s);
        a_qy_reg   <= qy_s[DW-1] ? AW'(-qy_s) : AW'(qy_s);
        a_addr_reg <= {row_reg, col_reg};
        b_pp_reg   <= a_px_reg * a_px_reg;
        b_qq_reg   <= a_qy_reg * a_qy_reg;
        b_addr_reg <= a_addr_reg;
        c_d2_reg   <= D2_W'(b_pp_reg) + D2_W'(b_qq_reg);
        c_addr_reg <= b_addr_reg;
    end

    logic inside_outer;
    logic outside_inner;
    logic mem_we;
    logic mem_re;
    logic [7:0] mem_wdata;

    assign inside_outer  = c_d2_reg <= D2_W'(rr_reg);
    assign outside_inner = !outline_reg || r1_neg_reg || (c_d2_reg > D2_W'(rr1_reg));
    assign mem_we        = vc_reg && (clear_mode_reg || (inside_outer && outside_inner));
    assign mem_wdata     = clear_mode_reg ? background_reg : color_reg;

    // Pixel reads go out at accept; data lands during ST_READ.
    assign mem_re = s_accept && (s_data.req_type == crfe_pkg::REQ_READ) && !read_oob;

    crfe_ram #(
        .DATA_W (8),
        .DEPTH  (2 ** ADDR_W)
    ) u_frame_ram (
        .clk     (aclk),
        .wr_en   (mem_we),
        .wr_addr (c_addr_reg),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr ({ROW_W'(s_data.read_row), COL_W'(s_data.read_col)}),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    crfe_pkg::rsp_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.status      <= res_status_reg;
            m_data_reg.pixel_value <= res_pix_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_accept, !s_ready)
    `ASSERT_NEVER(a_no_rw_overlap, aclk, aresetn, mem_we && mem_re)
    `ASSERT_IMPLIES(a_idle_pipe_empty, aclk, aresetn,
        state_reg == crfe_pkg::ST_IDLE, !pipe_busy)
    `ASSERT_IMPLIES(a_write_during_sweep, aclk, aresetn, mem_we,
        state_reg == crfe_pkg::ST_SWEEP || state_reg == crfe_pkg::ST_DRAIN)

endmodule

`default_nettype wire
